// File: src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_REAR  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_REAR  = 3'd3,
        REQ_DUMP      = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } stat_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

endpackage

// File: src/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/double_ended_queue_unit.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH items held in a ring in one RAM with a
// registered read port and a separate write port. A request is a transfer
// of req_type and item_value; each request produces one or more result
// transfers, the final one marked by last_of_run. Inserts, refused inserts,
// removals or dumps from an empty queue and unknown request types load
// their result in the cycle of the request, so the result is valid in the
// cycle after. A removal reads the RAM into the RAM output register and then
// moves the item to the output register. A dump streams one held item per
// cycle from front to rear while out_ready accepts the results, because the
// single RAM read port supplies one entry a cycle. A new request is taken
// once the previous one has produced all of its results and the output
// register is free or being emptied.
module double_ended_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               has_value,
    output logic signed [31:0] out_value,
    output logic [4:0]         occupancy,
    output logic               last_of_run
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       run_base_reg, run_base_next;
    logic [CW-1:0]       run_len_reg, run_len_next;
    logic [CW-1:0]       issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                d_vld_reg, d_vld_next;

    logic                out_valid_reg, out_valid_next;
    stat_t               status_reg, status_next;
    logic                has_value_reg, has_value_next;
    logic signed [31:0]  out_value_reg, out_value_next;
    logic [4:0]          occupancy_reg, occupancy_next;
    logic                last_reg, last_next;

    logic                slot_free;
    logic                in_xfer;
    logic                take;
    logic                issue;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic signed [31:0]  rd_value;
    logic [AW-1:0]       front_dec;
    logic [AW-1:0]       front_inc;
    logic [AW-1:0]       rear_ins;
    logic [AW-1:0]       rear_last;
    logic                is_full;
    logic                is_empty;

    // Reduce a sum known to be below twice DEPTH to a ring position.
    function automatic logic [AW-1:0] ring_wrap(input logic [CW:0] sum);
        logic [CW:0] red;
        begin
            red = (sum >= (CW + 1)'(DEPTH)) ? sum - (CW + 1)'(DEPTH) : sum;
            ring_wrap = red[AW-1:0];
        end
    endfunction

    generate
        if (DATA_WIDTH <= 32)
        begin : g_narrow
            assign wr_data  = item_value[DATA_WIDTH-1:0];
            assign rd_value = 32'($signed(rd_data));
        end
        else
        begin : g_wide
            assign wr_data  = DATA_WIDTH'($unsigned(item_value));
            assign rd_value = $signed(rd_data[31:0]);
        end
    endgenerate

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_xfer   = in_valid && in_ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign rear_ins  = ring_wrap((CW + 1)'(front_reg) + (CW + 1)'(count_reg));
    assign rear_last = ring_wrap((CW + 1)'(front_reg) + (CW + 1)'(count_reg)
                                 - (CW + 1)'(1));

    // The RAM output holds one fetched item until it moves to the output
    // register; the next read is issued only when that slot empties.
    assign take    = d_vld_reg && slot_free;
    assign issue   = (state_reg == S_RUN) && (issue_cnt_reg != run_len_reg)
                     && (!d_vld_reg || take);
    assign rd_addr = ring_wrap((CW + 1)'(run_base_reg) + (CW + 1)'(issue_cnt_reg));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        run_base_next  = run_base_reg;
        run_len_next   = run_len_reg;
        issue_cnt_next = issue_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        d_vld_next     = d_vld_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        has_value_next = has_value_reg;
        out_value_next = out_value_reg;
        occupancy_next = occupancy_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = rear_ins;

        if (issue)
        begin
            issue_cnt_next = issue_cnt_reg + 1'b1;
            d_vld_next     = 1'b1;
        end
        else if (take)
        begin
            d_vld_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            has_value_next = 1'b1;
            out_value_next = rd_value;
            occupancy_next = 5'(count_reg);
            last_next      = (emit_cnt_reg + 1'b1 == run_len_reg);
            emit_cnt_next  = emit_cnt_reg + 1'b1;
            if (emit_cnt_reg + 1'b1 == run_len_reg)
            begin
                state_next = S_IDLE;
            end
        end

        if (in_xfer)
        begin
            status_next    = ST_OK;
            has_value_next = 1'b0;
            out_value_next = '0;
            last_next      = 1'b1;
            issue_cnt_next = '0;
            emit_cnt_next  = '0;
            out_valid_next = 1'b1;
            case (req_t'(req_type))
                REQ_INS_FRONT, REQ_INS_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (req_t'(req_type) == REQ_INS_FRONT)
                        begin
                            wr_addr    = front_dec;
                            front_next = front_dec;
                        end
                    end
                end
                REQ_REM_FRONT, REQ_REM_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_RUN;
                        run_len_next   = CW'(1);
                        count_next     = count_reg - 1'b1;
                        if (req_t'(req_type) == REQ_REM_FRONT)
                        begin
                            run_base_next = front_reg;
                            front_next    = front_inc;
                        end
                        else
                        begin
                            run_base_next = rear_last;
                        end
                    end
                end
                REQ_DUMP:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_RUN;
                        run_base_next  = front_reg;
                        run_len_next   = count_reg;
                    end
                end
                default:
                begin
                    // Unknown request types leave the queue untouched.
                end
            endcase
            occupancy_next = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            d_vld_reg     <= d_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_base_reg  <= run_base_next;
        run_len_reg   <= run_len_next;
        status_reg    <= status_next;
        has_value_reg <= has_value_next;
        out_value_reg <= out_value_next;
        occupancy_reg <= occupancy_next;
        last_reg      <= last_next;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign has_value   = has_value_reg;
    assign out_value   = out_value_reg;
    assign occupancy   = occupancy_reg;
    assign last_of_run = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("item count exceeds the ring depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < AW'(DEPTH - 1) || front_reg == AW'(DEPTH - 1))
        else $error("front index outside the ring");

    a_fetch_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> state_reg == S_RUN)
        else $error("fetched item pending outside a run");

    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> state_reg == S_RUN)
        else $error("non-final result while no run is active");

    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !wr_en)
        else $error("ring written while a run is reading it");
`endif

endmodule
